// File: hw/rtl/btb_gshare_branch_predictor_defines.svh
// Assertion macros used by the checker file.
`ifndef BTB_GSHARE_BRANCH_PREDICTOR_DEFINES_SVH
`define BTB_GSHARE_BRANCH_PREDICTOR_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define BGP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bgp check failed");

// Next-cycle implication, disabled in reset
`define BGP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bgp check failed");

`endif

// File: hw/rtl/bgp_pkg.sv
package bgp_pkg;

  localparam int SET_COUNT   = 1024;
  localparam int SET_W       = $clog2(SET_COUNT);
  localparam int WAY_COUNT   = 4;
  localparam int CTR_ENTRIES = 4096;
  localparam int CTR_W       = $clog2(CTR_ENTRIES);
  localparam int HIST_W      = 12;

  localparam logic [1:0] CTR_RESET = 2'd2;

  // Register map, index = paddr / 4
  typedef enum logic [2:0] {
    REG_WAYS    = 3'd0,
    REG_SETS    = 3'd1,
    REG_ALIGN   = 3'd2,
    REG_CTRBITS = 3'd3,
    REG_HIST    = 3'd4
  } reg_idx_t;

  // Misprediction classes
  typedef enum logic [1:0] {
    OUT_CORRECT  = 2'd0,
    OUT_TAKEN_MISS = 2'd1,
    OUT_DIR_WRONG  = 2'd2,
    OUT_TGT_WRONG  = 2'd3
  } outcome_t;

  // One target buffer set: all ways side by side
  typedef struct packed {
    logic [WAY_COUNT-1:0]       valid;
    logic [WAY_COUNT-1:0][31:0] stamp;
    logic [WAY_COUNT-1:0][31:0] tag;
    logic [WAY_COUNT-1:0][31:0] target;
  } btb_row_t;

endpackage

// File: hw/rtl/btb_gshare_branch_predictor.sv
// Branch predictor with a 4-way, 1024-set target buffer and 4096 2-bit gshare
// counters, fed one traced (pc, next_pc) word per cycle unless stalled. Each word
// goes through a memory read, then compare and write-back into the output
// register, and a new word is taken every cycle while the output is drained;
// back-to-back writes to the same set or counter are forwarded. After reset a
// clearing pass over all 4096 counter entries initializes the counters and the
// buffer; no word is accepted during it, configuration writes are. Configure
// only while idle.
module btb_gshare_branch_predictor (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // pc[31:0], next_pc[63:32]
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // taken, buffer_hit, predict_jump,
                                 // predicted_target[34:3], outcome[36:35], zero
);
  import bgp_pkg::*;

  // ---------------- configuration ----------------
  logic [2:0] ways_in_use;
  logic [3:0] set_bits;
  logic [2:0] align_shift;
  logic [3:0] counter_bits;
  logic [3:0] history_len;
  logic       cfg_wr;
  reg_idx_t   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_in_use  <= 3'd1;
      set_bits     <= 4'd0;
      align_shift  <= 3'd2;
      counter_bits <= 4'd4;
      history_len  <= 4'd0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WAYS:    ways_in_use  <= pwdata[2:0];
        REG_SETS:    set_bits     <= pwdata[3:0];
        REG_ALIGN:   align_shift  <= pwdata[2:0];
        REG_CTRBITS: counter_bits <= pwdata[3:0];
        REG_HIST:    history_len  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WAYS:    prdata = {29'd0, ways_in_use};
      REG_SETS:    prdata = {28'd0, set_bits};
      REG_ALIGN:   prdata = {29'd0, align_shift};
      REG_CTRBITS: prdata = {28'd0, counter_bits};
      REG_HIST:    prdata = {28'd0, history_len};
      default:     prdata = 32'd0;
    endcase
  end

  // Saturated configuration
  logic [2:0]        ways;
  logic [3:0]        sb;
  logic [3:0]        cb;
  logic [3:0]        hl;
  logic [SET_W-1:0]  set_mask;
  logic [CTR_W-1:0]  ctr_mask;
  logic [HIST_W-1:0] hmask;

  always_comb begin
    ways = (ways_in_use == 3'd0) ? 3'd1 :
           (ways_in_use > 3'(WAY_COUNT)) ? 3'(WAY_COUNT) : ways_in_use;
    sb   = (set_bits > 4'(SET_W)) ? 4'(SET_W) : set_bits;
    cb   = (counter_bits > 4'(CTR_W)) ? 4'(CTR_W) : counter_bits;
    hl   = (history_len > 4'(HIST_W)) ? 4'(HIST_W) : history_len;
    set_mask = (SET_W'(1) << sb) - SET_W'(1);
    ctr_mask = (CTR_W'(1) << cb) - CTR_W'(1);
    hmask    = (HIST_W'(1) << hl) - HIST_W'(1);
  end

  // ---------------- clearing pass ----------------
  logic             clr_busy;
  logic [CTR_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      clr_idx <= clr_idx + CTR_W'(1);
      if (clr_idx == CTR_W'(CTR_ENTRIES - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // ---------------- handshake ----------------
  logic s1_valid;
  logic s1_free;
  logic s1_go;
  logic acc;

  assign s1_free  = !m_tvalid || m_tready;
  assign s1_go    = s1_valid && s1_free;
  assign s_tready = !clr_busy && (!s1_valid || s1_free);
  assign acc      = s_tvalid && s_tready;

  // ---------------- stage 0: index ----------------
  logic [31:0]       in_pc;
  logic [31:0]       in_npc;
  logic [31:0]       pc_bits;
  logic [4:0]        tag_lsb;
  logic [SET_W-1:0]  set0;
  logic [31:0]       tag0;
  logic [HIST_W-1:0] hist;
  logic [HIST_W-1:0] hist_sh;
  logic [CTR_W-1:0]  cidx_a0;
  logic [CTR_W-1:0]  cidx_b0;
  logic              s1_taken;

  assign in_pc     = s_tdata[31:0];
  assign in_npc    = s_tdata[63:32];
  assign pc_bits   = in_pc >> align_shift;
  assign tag_lsb   = 5'(align_shift) + 5'(sb);
  assign set0      = pc_bits[SET_W-1:0] & set_mask;
  assign tag0      = in_pc >> tag_lsb;
  // second candidate: history after the word now in stage 1 shifts in
  assign hist_sh   = ((hist << 1) | HIST_W'(s1_taken)) & hmask;
  assign cidx_a0   = (pc_bits[CTR_W-1:0] ^ CTR_W'(hist & hmask)) & ctr_mask;
  assign cidx_b0   = (pc_bits[CTR_W-1:0] ^ CTR_W'(hist_sh)) & ctr_mask;

  // ---------------- memories ----------------
  btb_row_t         rd_row;
  btb_row_t         wr_row;
  logic             btb_wr;
  logic [SET_W-1:0] s1_set;
  logic             btb_we;
  logic [SET_W-1:0] btb_waddr;
  btb_row_t         btb_wdata;

  assign btb_we    = clr_busy ? (clr_idx[CTR_W-1:SET_W] == '0) : btb_wr;
  assign btb_waddr = clr_busy ? clr_idx[SET_W-1:0] : s1_set;
  assign btb_wdata = clr_busy ? btb_row_t'('0) : wr_row;

  bgp_btb_mem u_btb (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (set0),
    .rd_row  (rd_row),
    .wr_en   (btb_we),
    .wr_addr (btb_waddr),
    .wr_row  (btb_wdata)
  );

  logic [1:0]       rd_ctr_a;
  logic [1:0]       rd_ctr_b;
  logic             ctr_wr;
  logic [CTR_W-1:0] ctr_waddr;
  logic [1:0]       ctr_wdata;

  bgp_ctr_mem u_ctr (
    .clk       (clk),
    .rd_en     (acc),
    .rd_addr_a (cidx_a0),
    .rd_addr_b (cidx_b0),
    .rd_data_a (rd_ctr_a),
    .rd_data_b (rd_ctr_b),
    .wr_en     (clr_busy || ctr_wr),
    .wr_addr   (clr_busy ? clr_idx : ctr_waddr),
    .wr_data   (clr_busy ? CTR_RESET : ctr_wdata)
  );

  // ---------------- stage 1 registers ----------------
  logic [31:0]      s1_npc;
  logic [31:0]      s1_tag;
  logic [CTR_W-1:0] s1_cidx_a;
  logic [CTR_W-1:0] s1_cidx_b;
  logic             s1_sel_b;
  logic             f_row;
  btb_row_t         f_row_data;
  logic             f_ca;
  logic             f_cb;
  logic [1:0]       f_ctr_data;
  logic             upd;
  logic [31:0]      access_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // payload plus forwarding of a write that lands on the read edge
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_npc     <= in_npc;
      s1_tag     <= tag0;
      s1_set     <= set0;
      s1_taken   <= in_npc != in_pc + 32'd4;
      s1_cidx_a  <= cidx_a0;
      s1_cidx_b  <= cidx_b0;
      s1_sel_b   <= s1_go && upd;
      f_row      <= btb_wr && (s1_set == set0);
      f_row_data <= wr_row;
      f_ca       <= ctr_wr && (ctr_waddr == cidx_a0);
      f_cb       <= ctr_wr && (ctr_waddr == cidx_b0);
      f_ctr_data <= ctr_wdata;
    end
  end

  // ---------------- stage 1: lookup and update ----------------
  btb_row_t   row;
  logic       hit;
  logic [1:0] hit_way;
  logic [1:0] victim;
  logic [31:0] oldest;
  logic       done;
  logic [1:0] ctr;
  logic       dir_taken;
  logic [31:0] ptarget;
  outcome_t   outcome;
  logic [31:0] stamp;

  assign row   = f_row ? f_row_data : rd_row;
  assign stamp = access_count + 32'd1;

  always_comb begin
    hit     = 1'b0;
    hit_way = 2'd0;
    victim  = 2'd0;
    oldest  = 32'hffff_ffff;
    done    = 1'b0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (!done && (3'(w) < ways)) begin
        if (row.valid[w] && (row.tag[w] == s1_tag)) begin
          hit     = 1'b1;
          hit_way = 2'(w);
          done    = 1'b1;
        end else if (row.stamp[w] < oldest) begin
          oldest = row.stamp[w];
          victim = 2'(w);
        end
      end
    end
  end

  always_comb begin
    if (s1_sel_b) begin
      ctr       = f_cb ? f_ctr_data : rd_ctr_b;
      ctr_waddr = s1_cidx_b;
    end else begin
      ctr       = f_ca ? f_ctr_data : rd_ctr_a;
      ctr_waddr = s1_cidx_a;
    end
    dir_taken = ctr[1];
    ptarget   = hit ? row.target[hit_way] : 32'd0;

    outcome = OUT_CORRECT;
    if (hit) begin
      if (dir_taken) begin
        if (!s1_taken) begin
          outcome = OUT_DIR_WRONG;
        end else if (ptarget != s1_npc) begin
          outcome = OUT_TGT_WRONG;
        end
      end else if (s1_taken) begin
        outcome = OUT_DIR_WRONG;
      end
    end else if (s1_taken) begin
      outcome = OUT_TAKEN_MISS;
    end

    // row write-back
    wr_row = row;
    if (hit) begin
      wr_row.stamp[hit_way] = stamp;
      if (s1_taken) begin
        wr_row.target[hit_way] = s1_npc;
      end
    end else begin
      wr_row.tag[victim]    = s1_tag;
      wr_row.target[victim] = s1_npc;
      wr_row.valid[victim]  = 1'b1;
      wr_row.stamp[victim]  = stamp;
    end

    upd    = hit || s1_taken;
    btb_wr = s1_go && upd;
    ctr_wr = s1_go && upd;

    // saturating counter
    if (s1_taken) begin
      ctr_wdata = (ctr == 2'd3) ? ctr : ctr + 2'd1;
    end else begin
      ctr_wdata = (ctr == 2'd0) ? ctr : ctr - 2'd1;
    end
  end

  // history and access count
  always_ff @(posedge clk) begin
    if (rst) begin
      hist         <= '0;
      access_count <= '0;
    end else if (s1_go) begin
      access_count <= stamp;
      if (upd && (hl != 4'd0)) begin
        hist <= hist_sh;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      m_tdata <= {3'd0, outcome, ptarget, hit && dir_taken, hit, s1_taken};
    end
  end

endmodule

// File: hw/rtl/bgp_btb_mem.sv
module bgp_btb_mem (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [bgp_pkg::SET_W-1:0]    rd_addr,
  output bgp_pkg::btb_row_t            rd_row,
  input  logic                         wr_en,
  input  logic [bgp_pkg::SET_W-1:0]    wr_addr,
  input  bgp_pkg::btb_row_t            wr_row
);
  import bgp_pkg::*;

  btb_row_t mem [SET_COUNT];

  // One row per set, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/bgp_ctr_mem.sv
module bgp_ctr_mem (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [bgp_pkg::CTR_W-1:0] rd_addr_a,
  input  logic [bgp_pkg::CTR_W-1:0] rd_addr_b,
  output logic [1:0]                rd_data_a,
  output logic [1:0]                rd_data_b,
  input  logic                      wr_en,
  input  logic [bgp_pkg::CTR_W-1:0] wr_addr,
  input  logic [1:0]                wr_data
);
  import bgp_pkg::*;

  logic [1:0] mem [CTR_ENTRIES];

  // Two read ports: index with current history and with shifted history
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// File: hw/rtl/bgp_checker.sv
module bgp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);
`include "btb_gshare_branch_predictor_defines.svh"

  // stalled result word holds
  `BGP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // a jump is predicted only on a buffer hit
  `BGP_ASSERT_NOW(a_pj_hit, m_tvalid && m_tdata[2], m_tdata[1])
  // a miss shows no target
  `BGP_ASSERT_NOW(a_miss_tgt, m_tvalid && !m_tdata[1], m_tdata[34:3] == 32'd0)
  // taken-miss class only for a taken word that missed
  `BGP_ASSERT_NOW(a_cls, m_tvalid && (m_tdata[36:35] == 2'd1), m_tdata[0] && !m_tdata[1])
  // an accepted word must show up as a valid result word once it has passed stage 1 and the output register
  `BGP_ASSERT_NOW(a_acc_res, $past(s_tvalid && s_tready, 2), m_tvalid)

endmodule

bind btb_gshare_branch_predictor bgp_checker u_bgp_checker (.*);
